// File: sv/wpm_pkg.sv
// wildcard pattern matcher package: beat types, action codes, command struct
// and symbol constants; no dependencies
`default_nettype none

package wpm_pkg;

  localparam int PatternMaxDef = 32;

  localparam logic [7:0] SymStar = 8'd42;
  localparam logic [7:0] SymAny  = 8'd63;

  typedef enum logic [1:0] {
    ActClear  = 2'd0,
    ActAppend = 2'd1,
    ActText   = 2'd2,
    ActFinish = 2'd3
  } action_e;

  typedef struct packed {
    action_e    action;
    logic [7:0] symbol;
  } in_t;

  typedef struct packed {
    logic matched;
    logic pattern_overflow;
  } out_t;

  typedef struct packed {
    logic clear;
    logic append;
    logic text;
    logic finish;
  } cmd_t;

  typedef enum logic {
    StEmpty = 1'b0,
    StFull  = 1'b1
  } state_e;

endpackage

`default_nettype wire

// File: sv/wpm_ctrl.sv
// wildcard pattern matcher controller: handshakes and output register state
// depends on wpm_pkg
`default_nettype none

module wpm_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire wpm_pkg::action_e in_action_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output wpm_pkg::cmd_t         cmd_o
);

  wpm_pkg::state_e state_q, state_d;
  logic accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wpm_pkg::StEmpty;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    in_ready_o  = (state_q == wpm_pkg::StEmpty) || out_ready_i;
    out_valid_o = (state_q == wpm_pkg::StFull);
    accept      = in_valid_i && in_ready_o;
    cmd_o.clear  = accept && (in_action_i == wpm_pkg::ActClear);
    cmd_o.append = accept && (in_action_i == wpm_pkg::ActAppend);
    cmd_o.text   = accept && (in_action_i == wpm_pkg::ActText);
    cmd_o.finish = accept && (in_action_i == wpm_pkg::ActFinish);
    state_d = state_q;
    case (state_q)
      wpm_pkg::StEmpty: begin
        if (cmd_o.finish) state_d = wpm_pkg::StFull;
      end
      wpm_pkg::StFull: begin
        if (out_ready_i && !cmd_o.finish) state_d = wpm_pkg::StEmpty;
      end
      default: state_d = wpm_pkg::StEmpty;
    endcase
  end

endmodule

`default_nettype wire

// File: sv/wpm_datapath.sv
// wildcard pattern matcher datapath: pattern registers, match row with a
// segmented prefix-or network for stars, result register; depends on wpm_pkg
`default_nettype none

module wpm_datapath #(
  parameter int PatternMax = wpm_pkg::PatternMaxDef
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire wpm_pkg::cmd_t cmd_i,
  input  wire logic [7:0]    symbol_i,
  output wpm_pkg::out_t      out_data_o
);

  localparam int LenW   = $clog2(PatternMax + 1);
  localparam int IdxW   = (PatternMax > 1) ? $clog2(PatternMax) : 1;
  localparam int Levels = (PatternMax > 1) ? $clog2(PatternMax) : 1;

  logic [7:0]          pat_q [PatternMax];
  logic [LenW-1:0]     len_q, len_d;
  logic [LenW-1:0]     lead_q, lead_d;
  logic [PatternMax:0] row_q, row_d;
  logic                act_q, act_d;
  logic                ovf_q, ovf_d;
  logic                room;
  logic [PatternMax:0] eff_row;
  logic [PatternMax:0] next_row;
  wpm_pkg::out_t       out_q;

  assign room = (len_q < LenW'(PatternMax));

  // row for the text so far, or the empty-text row of leading stars
  always_comb begin
    for (int j = 0; j <= PatternMax; j++) begin
      eff_row[j] = act_q ? row_q[j] : (LenW'(j) <= lead_q);
    end
  end

  always_comb begin
    logic [PatternMax:0] g, p, gp, pp;
    int d;
    g = '0;
    p = '0;
    for (int j = 1; j <= PatternMax; j++) begin
      if (pat_q[j-1] == wpm_pkg::SymStar) begin
        g[j] = eff_row[j];
        p[j] = 1'b1;
      end else if (pat_q[j-1] == wpm_pkg::SymAny || pat_q[j-1] == symbol_i) begin
        g[j] = eff_row[j-1];
      end
    end
    for (int lv = 0; lv < Levels; lv++) begin
      d  = 1 << lv;
      gp = g;
      pp = p;
      for (int j = 1; j <= PatternMax; j++) begin
        if (j > d) begin
          g[j] = gp[j] | (pp[j] & gp[j-d]);
          p[j] = pp[j] & pp[j-d];
        end
      end
    end
    next_row = g;
  end

  always_comb begin
    len_d  = len_q;
    lead_d = lead_q;
    row_d  = row_q;
    act_d  = act_q;
    ovf_d  = ovf_q;
    if (cmd_i.clear) begin
      len_d  = '0;
      lead_d = '0;
      ovf_d  = 1'b0;
      act_d  = 1'b0;
    end
    if (cmd_i.append) begin
      act_d = 1'b0;
      if (room) begin
        len_d = len_q + LenW'(1);
        if (lead_q == len_q && symbol_i == wpm_pkg::SymStar) lead_d = lead_q + LenW'(1);
      end else begin
        ovf_d = 1'b1;
      end
    end
    if (cmd_i.text) begin
      row_d = next_row;
      act_d = 1'b1;
    end
    if (cmd_i.finish) begin
      act_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= '0;
      lead_q <= '0;
      row_q  <= '0;
      act_q  <= 1'b0;
      ovf_q  <= 1'b0;
    end else begin
      len_q  <= len_d;
      lead_q <= lead_d;
      row_q  <= row_d;
      act_q  <= act_d;
      ovf_q  <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.append && room) begin
      pat_q[len_q[IdxW-1:0]] <= symbol_i;
    end
    if (cmd_i.finish) begin
      out_q.matched          <= eff_row[len_q];
      out_q.pattern_overflow <= ovf_q;
    end
  end

  assign out_data_o = out_q;

endmodule

`default_nettype wire

// File: sv/wildcard_pattern_matcher_top.sv
// wildcard pattern matcher top level: controller and datapath
// depends on wpm_pkg, wpm_ctrl, wpm_datapath
//
// usage: each input beat carries an action and a symbol. clear empties the
// pattern and its overflow flag, append adds one pattern byte ('*' any run,
// '?' any one byte), text feeds one text byte, finish ends the text and
// produces one result beat (matched, pattern_overflow). other actions
// produce no result. appends beyond PatternMax bytes are dropped and flagged.
// throughput: one input beat per cycle, every action, unless a result waits
// and out_ready_i is low; the whole match row is computed combinationally
// through a segmented prefix-or network across the pattern positions.
// result: a finish result appears in the output register the cycle after
// the finish beat is accepted.
// stall: while a result waits and out_ready_i is low, in_ready_o is low;
// when out_ready_i is high a new beat is taken in the same cycle.
// reset: pattern length, match state, overflow flag and the output valid
// clear at once; pattern bytes are unknown until written.
`default_nettype none

module wildcard_pattern_matcher_top #(
  parameter int PatternMax = wpm_pkg::PatternMaxDef
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire wpm_pkg::in_t in_data_i,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output wpm_pkg::out_t     out_data_o
);

  wpm_pkg::cmd_t cmd;

  wpm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_action_i (in_data_i.action),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  wpm_datapath #(
    .PatternMax (PatternMax)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .symbol_i   (in_data_i.symbol),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire

// File: sv/wpm_checker.sv
// wildcard pattern matcher port checker and its bind to the top level
// depends on wpm_pkg
`default_nettype none

module wpm_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          in_valid_i,
  input wire logic          in_ready_o,
  input wire wpm_pkg::in_t  in_data_i,
  input wire logic          out_valid_o,
  input wire logic          out_ready_i,
  input wire wpm_pkg::out_t out_data_o
);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_o;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  a_result_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_acc && in_data_i.action == wpm_pkg::ActFinish))
    else $error("result beat without a finish");

  a_ready_only_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without a waiting result");

  a_empty_pattern: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_data_i.action == wpm_pkg::ActClear) ##1
    (in_acc && in_data_i.action == wpm_pkg::ActFinish)
    |=> out_data_o.matched && !out_data_o.pattern_overflow)
    else $error("empty text against empty pattern must match");

endmodule

bind wildcard_pattern_matcher_top wpm_checker u_wpm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
